[hdl/lmpm_pkg.sv]
// Shared types, register codes and helpers for the LED matrix pixel mapper.
package lmpm_pkg;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        CFG_WIDTH_COLS      = 3'd0,
        CFG_HEIGHT_ROWS     = 3'd1,
        CFG_STRIP_LENGTH    = 3'd2,
        CFG_LAYOUT_MODE     = 3'd3,
        CFG_CHANNEL_ORDER   = 3'd4,
        CFG_DIM_LEVEL       = 3'd5,
        CFG_OVERRIDE_ENABLE = 3'd6,
        CFG_OVERRIDE_COLOUR = 3'd7
    } t_cfg_reg;

    // Register reset values
    localparam logic [8:0]  RST_WIDTH_COLS    = 9'd16;
    localparam logic [8:0]  RST_HEIGHT_ROWS   = 9'd16;
    localparam logic [15:0] RST_STRIP_LENGTH  = 16'd256;
    localparam logic [3:0]  RST_LAYOUT_MODE   = 4'd0;
    localparam logic [7:0]  RST_CHANNEL_ORDER = 8'd82;
    localparam logic [7:0]  RST_DIM_LEVEL     = 8'd0;
    localparam logic [31:0] RST_OVR_COLOUR    = 32'd0;

    // Layout flag bits
    localparam int LAYOUT_BOTTOM = 0;
    localparam int LAYOUT_RIGHT  = 1;
    localparam int LAYOUT_COLMAJ = 2;
    localparam int LAYOUT_ZIGZAG = 3;

    // Slot offset that three-byte mode drops
    localparam logic [1:0] SLOT_LAST = 2'b11;

    // Draw request
    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [31:0]        rgbw_in;
    } t_pix_req;

    // Mapped result
    typedef struct packed {
        logic        accepted;
        logic [15:0] led_index;
        logic [17:0] byte_address;
        logic        four_byte_mode;
        logic [7:0]  slot_byte0;
        logic [7:0]  slot_byte1;
        logic [7:0]  slot_byte2;
        logic [7:0]  slot_byte3;
    } t_pix_res;

    // Packed slot bytes in wire order, plus the RGBW flag
    typedef struct packed {
        logic            four;
        logic [3:0][7:0] bytes;
    } t_slot_set;

    // Brightness scale of one channel: (c*lvl)>>8, or c when lvl is zero
    function automatic logic [7:0] dim8(input logic [7:0] c, input logic [7:0] lvl);
        logic [15:0] prod;
        prod = {8'd0, c} * {8'd0, lvl};
        return (lvl == 8'd0) ? c : prod[15:8];
    endfunction

endpackage

[hdl/lmpm_slot_pack.sv]
// Places dimmed W/R/G/B bytes into the pixel slot by their per-channel offsets.
module lmpm_slot_pack
    import lmpm_pkg::*;
(
    input  logic [31:0] i_colour,
    input  logic [7:0]  i_channel_order,
    output t_slot_set   o_slot
);

    logic [1:0] woff, roff, goff, boff;
    logic       four;

    assign woff = i_channel_order[7:6];
    assign roff = i_channel_order[5:4];
    assign goff = i_channel_order[3:2];
    assign boff = i_channel_order[1:0];
    assign four = (woff != roff);

    // Writes go white, red, green, blue: the last matching channel wins
    always_comb begin
        o_slot.four = four;
        for (int k = 0; k < 4; k++) begin
            if (!four && (2'(k) == SLOT_LAST)) begin
                o_slot.bytes[k] = 8'd0;
            end else if (boff == 2'(k)) begin
                o_slot.bytes[k] = i_colour[7:0];
            end else if (goff == 2'(k)) begin
                o_slot.bytes[k] = i_colour[15:8];
            end else if (roff == 2'(k)) begin
                o_slot.bytes[k] = i_colour[23:16];
            end else if (four && (woff == 2'(k))) begin
                o_slot.bytes[k] = i_colour[31:24];
            end else begin
                o_slot.bytes[k] = 8'd0;
            end
        end
    end

endmodule

[hdl/led_matrix_pixel_mapper.sv]
// Top level of the LED matrix pixel mapper: five-stage request pipeline and config registers.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------
//  request | in        | i_in_valid / o_in_stall    | i_in_req  (t_pix_req)
//  result  | out       | o_out_valid / i_out_stall  | o_out_res (t_pix_res)
//  config  | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  One request per cycle unless stalled; each result is valid at the output once its
//  request has passed five registers (input reg, map, multiply,
//  index add/compare, output reg).
//  Every stage holds when the stage after it is full and stalled, so with all stages
//  full a result-side stall backs up to o_in_stall in the same cycle; nothing is dropped.
//  Synchronous active-low reset clears the stage valids and loads register defaults.
//  The config port is always ready.
module led_matrix_pixel_mapper
    import lmpm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_pix_req    i_in_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_pix_res    o_out_res,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    // Configuration registers
    logic [8:0]  r_width_cols;
    logic [8:0]  r_height_rows;
    logic [15:0] r_strip_length;
    logic [3:0]  r_layout_mode;
    logic [7:0]  r_channel_order;
    logic [7:0]  r_dim_level;
    logic        r_override_enable;
    logic [31:0] r_override_colour;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_cols      <= RST_WIDTH_COLS;
            r_height_rows     <= RST_HEIGHT_ROWS;
            r_strip_length    <= RST_STRIP_LENGTH;
            r_layout_mode     <= RST_LAYOUT_MODE;
            r_channel_order   <= RST_CHANNEL_ORDER;
            r_dim_level       <= RST_DIM_LEVEL;
            r_override_enable <= 1'b0;
            r_override_colour <= RST_OVR_COLOUR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_WIDTH_COLS:      r_width_cols      <= i_cfg_data[8:0];
                CFG_HEIGHT_ROWS:     r_height_rows     <= i_cfg_data[8:0];
                CFG_STRIP_LENGTH:    r_strip_length    <= i_cfg_data[15:0];
                CFG_LAYOUT_MODE:     r_layout_mode     <= i_cfg_data[3:0];
                CFG_CHANNEL_ORDER:   r_channel_order   <= i_cfg_data[7:0];
                CFG_DIM_LEVEL:       r_dim_level       <= i_cfg_data[7:0];
                CFG_OVERRIDE_ENABLE: r_override_enable <= i_cfg_data[0];
                CFG_OVERRIDE_COLOUR: r_override_colour <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage valids and advance enables
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_out_valid;
    logic en1, en2, en3, en4, en_out;

    assign en_out     = !r_out_valid || !i_out_stall;
    assign en4        = !r_s4_valid || en_out;
    assign en3        = !r_s3_valid || en4;
    assign en2        = !r_s2_valid || en3;
    assign en1        = !r_s1_valid || en2;
    assign o_in_stall = !en1;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en1)    r_s1_valid  <= i_in_valid;
            if (en2)    r_s2_valid  <= r_s1_valid;
            if (en3)    r_s3_valid  <= r_s2_valid;
            if (en4)    r_s4_valid  <= r_s3_valid;
            if (en_out) r_out_valid <= r_s4_valid;
        end
    end

    // Stage 1: input register
    t_pix_req r_s1_req;

    always_ff @(posedge i_clk) begin
        if (en1) r_s1_req <= i_in_req;
    end

    // Stage 2: bounds check, mirror, axis swap, colour select
    logic        n_s2_ok;
    logic [8:0]  n_s2_major, n_s2_minor, n_s2_scale;
    logic [8:0]  mir_x, mir_y;
    logic [15:0] ux, uy;

    assign ux = r_s1_req.pos_x;
    assign uy = r_s1_req.pos_y;

    always_comb begin
        n_s2_ok = !ux[15] && !uy[15] &&
                  (ux < {7'd0, r_width_cols}) && (uy < {7'd0, r_height_rows});
        mir_x = r_layout_mode[LAYOUT_RIGHT]  ? (r_width_cols - 9'd1 - ux[8:0])  : ux[8:0];
        mir_y = r_layout_mode[LAYOUT_BOTTOM] ? (r_height_rows - 9'd1 - uy[8:0]) : uy[8:0];
        if (r_layout_mode[LAYOUT_COLMAJ]) begin
            n_s2_major = mir_x;
            n_s2_minor = mir_y;
            n_s2_scale = r_height_rows;
        end else begin
            n_s2_major = mir_y;
            n_s2_minor = mir_x;
            n_s2_scale = r_width_cols;
        end
    end

    logic        r_s2_ok, r_s2_zig;
    logic [8:0]  r_s2_major, r_s2_minor, r_s2_scale;
    logic [31:0] r_s2_colour;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_ok     <= n_s2_ok;
            r_s2_zig    <= r_layout_mode[LAYOUT_ZIGZAG] && n_s2_major[0];
            r_s2_major  <= n_s2_major;
            r_s2_minor  <= n_s2_minor;
            r_s2_scale  <= n_s2_scale;
            r_s2_colour <= r_override_enable ? r_override_colour : r_s1_req.rgbw_in;
        end
    end

    // Stage 3: row base product and per-channel dimming
    logic        r_s3_ok, r_s3_zig;
    logic [17:0] r_s3_prod;
    logic [8:0]  r_s3_minor, r_s3_scale;
    logic [31:0] r_s3_colour;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_ok     <= r_s2_ok;
            r_s3_zig    <= r_s2_zig;
            r_s3_prod   <= {9'd0, r_s2_major} * {9'd0, r_s2_scale};
            r_s3_minor  <= r_s2_minor;
            r_s3_scale  <= r_s2_scale;
            r_s3_colour <= {dim8(r_s2_colour[31:24], r_dim_level),
                            dim8(r_s2_colour[23:16], r_dim_level),
                            dim8(r_s2_colour[15:8],  r_dim_level),
                            dim8(r_s2_colour[7:0],   r_dim_level)};
        end
    end

    // Stage 4: strip index and strip length check
    logic [17:0] n_s4_idx;

    // Odd serpentine lines run backward; for in-bounds requests minor is below scale, so no wrap
    assign n_s4_idx = r_s3_zig
        ? (r_s3_prod + {9'd0, r_s3_scale} - 18'd1 - {9'd0, r_s3_minor})
        : (r_s3_prod + {9'd0, r_s3_minor});

    logic        r_s4_ok;
    logic [15:0] r_s4_idx;
    logic [31:0] r_s4_colour;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_s4_ok     <= r_s3_ok && (n_s4_idx < {2'd0, r_strip_length});
            r_s4_idx    <= n_s4_idx[15:0];
            r_s4_colour <= r_s3_colour;
        end
    end

    // Output stage: slot packing and byte address
    t_slot_set slot;
    t_pix_res  n_out;
    logic [17:0] idx_ext;

    lmpm_slot_pack u_slot_pack (
        .i_colour        (r_s4_colour),
        .i_channel_order (r_channel_order),
        .o_slot          (slot)
    );

    assign idx_ext = {2'd0, r_s4_idx};

    always_comb begin
        n_out = '0;
        if (r_s4_ok) begin
            n_out.accepted       = 1'b1;
            n_out.led_index      = r_s4_idx;
            n_out.byte_address   = slot.four ? (idx_ext << 2) : ((idx_ext << 1) + idx_ext);
            n_out.four_byte_mode = slot.four;
            n_out.slot_byte0     = slot.bytes[0];
            n_out.slot_byte1     = slot.bytes[1];
            n_out.slot_byte2     = slot.bytes[2];
            n_out.slot_byte3     = slot.bytes[3];
        end
    end

    t_pix_res r_out;

    always_ff @(posedge i_clk) begin
        if (en_out) r_out <= n_out;
    end

    assign o_out_res = r_out;

endmodule

[dv/led_matrix_pixel_mapper_tb.sv]
// Self-checking testbench for the LED matrix pixel mapper: directed table, then randomized phases.
`timescale 1ns / 100ps

module led_matrix_pixel_mapper_tb;
    import lmpm_pkg::*;

    localparam int unsigned RUN_LIMIT_NS = 2_000_000;
    localparam int          PHASES       = 13;
    localparam int          PHASE_ITEMS  = 140;

    // Local copy of the register file
    typedef struct packed {
        logic [8:0]  width_cols;
        logic [8:0]  height_rows;
        logic [15:0] strip_length;
        logic [3:0]  layout_mode;
        logic [7:0]  channel_order;
        logic [7:0]  dim_level;
        logic        override_enable;
        logic [31:0] override_colour;
    } t_mapper_cfg;

    typedef enum int {
        STYLE_DEFAULT,
        STYLE_SMALL,
        STYLE_FULL,
        STYLE_MAX,
        STYLE_MIN
    } t_cfg_style;

    // One directed request, with its result typed in when known is set
    typedef struct {
        t_mapper_cfg cfg;
        t_pix_req    req;
        bit          known;
        t_pix_res    res;
    } t_table_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_pix_req    i_in_req    = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_pix_res    o_out_res;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data  = '0;

    t_mapper_cfg live_cfg = '{RST_WIDTH_COLS, RST_HEIGHT_ROWS, RST_STRIP_LENGTH,
                              RST_LAYOUT_MODE, RST_CHANNEL_ORDER, RST_DIM_LEVEL,
                              1'b0, RST_OVR_COLOUR};
    t_pix_res    pending_results [$];
    t_table_row  drive_table [$];
    bit          no_idle = 1'b0;
    int          errors  = 0;
    int          out_hold = 0;
    t_pix_res    want;

    led_matrix_pixel_mapper i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Brightness of one channel; level zero leaves it untouched
    function automatic logic [7:0] scale_channel(input logic [7:0] v, input logic [7:0] lvl);
        logic [15:0] prod;
        prod = {8'd0, v} * {8'd0, lvl};
        if (lvl == 8'd0)
            return v;
        return prod[15:8];
    endfunction

    // Expected result of one draw request under a register setting
    function automatic t_pix_res map_pixel(input t_pix_req rq, input t_mapper_cfg c);
        t_pix_res    res;
        int unsigned col, row, minor, major, span, idx, swap, addr;
        logic [31:0] colour;
        logic [1:0]  offs [4];
        logic [7:0]  chan [4];
        logic [7:0]  slot [4];
        bit          four;
        int          k;
        res = '0;
        // negative or off-matrix coordinates
        if (rq.pos_x[15] || rq.pos_y[15])
            return res;
        col = 32'(rq.pos_x[15:0]);
        row = 32'(rq.pos_y[15:0]);
        if (col >= 32'(c.width_cols) || row >= 32'(c.height_rows))
            return res;
        // start corner, then axis swap
        minor = col;
        major = row;
        if (c.layout_mode[LAYOUT_RIGHT])
            minor = 32'(c.width_cols) - 1 - minor;
        if (c.layout_mode[LAYOUT_BOTTOM])
            major = 32'(c.height_rows) - 1 - major;
        if (c.layout_mode[LAYOUT_COLMAJ]) begin
            swap  = major;
            major = minor;
            minor = swap;
            span  = 32'(c.height_rows);
        end else begin
            span = 32'(c.width_cols);
        end
        // odd lines run backwards in zigzag wiring
        if (c.layout_mode[LAYOUT_ZIGZAG] && major[0])
            idx = (major + 1) * span - 1 - minor;
        else
            idx = major * span + minor;
        if (idx >= 32'(c.strip_length))
            return res;
        colour = c.override_enable ? c.override_colour : rq.rgbw_in;
        // white, red, green, blue in write order; a later channel wins a shared offset
        offs = '{c.channel_order[7:6], c.channel_order[5:4],
                 c.channel_order[3:2], c.channel_order[1:0]};
        chan = '{colour[31:24], colour[23:16], colour[15:8], colour[7:0]};
        four = (offs[0] != offs[1]);
        slot = '{default: 8'h00};
        for (k = 0; k < 4; k++) begin
            if (four || (k != 0 && offs[k] != SLOT_LAST))
                slot[offs[k]] = scale_channel(chan[k], c.dim_level);
        end
        addr = idx * (four ? 4 : 3);
        res.accepted       = 1'b1;
        res.led_index      = idx[15:0];
        res.byte_address   = addr[17:0];
        res.four_byte_mode = four;
        res.slot_byte0     = slot[0];
        res.slot_byte1     = slot[1];
        res.slot_byte2     = slot[2];
        res.slot_byte3     = slot[3];
        return res;
    endfunction

    // Write data for one register, upper bits filled with junk
    function automatic logic [31:0] reg_word(input t_mapper_cfg c, input t_cfg_reg sel,
                                             input logic [31:0] junk);
        case (sel)
            CFG_WIDTH_COLS:      return {junk[31:9], c.width_cols};
            CFG_HEIGHT_ROWS:     return {junk[31:9], c.height_rows};
            CFG_STRIP_LENGTH:    return {junk[31:16], c.strip_length};
            CFG_LAYOUT_MODE:     return {junk[31:4], c.layout_mode};
            CFG_CHANNEL_ORDER:   return {junk[31:8], c.channel_order};
            CFG_DIM_LEVEL:       return {junk[31:8], c.dim_level};
            CFG_OVERRIDE_ENABLE: return {junk[31:1], c.override_enable};
            CFG_OVERRIDE_COLOUR: return c.override_colour;
            default:             return '0;
        endcase
    endfunction

    function automatic t_mapper_cfg rand_cfg(input t_cfg_style style);
        t_mapper_cfg c;
        int unsigned area;
        c = live_cfg;
        case (style)
            STYLE_DEFAULT: begin
                c = '{RST_WIDTH_COLS, RST_HEIGHT_ROWS, RST_STRIP_LENGTH, RST_LAYOUT_MODE,
                      RST_CHANNEL_ORDER, RST_DIM_LEVEL, 1'b0, RST_OVR_COLOUR};
            end
            STYLE_MAX: begin
                c = '{9'd256, 9'd256, 16'hFFFF, 4'hF, 8'hFF, 8'hFF, 1'b1, 32'hFFFF_FFFF};
            end
            STYLE_MIN: begin
                c = '{9'd1, 9'd1, 16'd0, 4'h0, 8'h00, 8'h00, 1'b0, 32'h0};
            end
            STYLE_FULL: begin
                c.width_cols      = 9'($urandom_range(0, 511));
                c.height_rows     = 9'($urandom_range(0, 511));
                c.strip_length    = 16'($urandom_range(0, 16'hFFFF));
                c.layout_mode     = 4'($urandom_range(0, 15));
                c.channel_order   = 8'($urandom_range(0, 255));
                c.dim_level       = 8'($urandom_range(0, 255));
                c.override_enable = 1'($urandom_range(0, 1));
                c.override_colour = $urandom;
            end
            default: begin
                // small matrix, strip length near the pixel count
                c.width_cols      = 9'($urandom_range(1, 24));
                c.height_rows     = 9'($urandom_range(1, 24));
                area              = 32'(c.width_cols) * 32'(c.height_rows);
                c.strip_length    = 16'($urandom_range(0, 1) ? area
                                                             : $urandom_range(0, area + 4));
                c.layout_mode     = 4'($urandom_range(0, 15));
                c.channel_order   = 8'($urandom_range(0, 255));
                c.dim_level       = ($urandom_range(0, 2) == 0) ? 8'd0
                                                                : 8'($urandom_range(1, 255));
                c.override_enable = ($urandom_range(0, 3) == 0);
                c.override_colour = $urandom;
            end
        endcase
        return c;
    endfunction

    // Mostly on-matrix pixels, some near the edges, a few anywhere
    function automatic t_pix_req rand_pixel(input t_mapper_cfg c);
        t_pix_req    rq;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        rq.rgbw_in = $urandom;
        if (pick < 80 && c.width_cols != 0 && c.height_rows != 0) begin
            rq.pos_x = 16'($urandom_range(0, c.width_cols - 1));
            rq.pos_y = 16'($urandom_range(0, c.height_rows - 1));
        end else if (pick < 92) begin
            rq.pos_x = 16'($urandom_range(0, c.width_cols + 3) - 2);
            rq.pos_y = 16'($urandom_range(0, c.height_rows + 3) - 2);
        end else begin
            rq.pos_x = 16'($urandom_range(0, 16'hFFFF));
            rq.pos_y = 16'($urandom_range(0, 16'hFFFF));
        end
        return rq;
    endfunction

    task automatic add_row(input t_mapper_cfg c, input int x, input int y,
                           input logic [31:0] colour, input bit known, input t_pix_res res);
        t_table_row row;
        row.cfg          = c;
        row.req.pos_x    = x[15:0];
        row.req.pos_y    = y[15:0];
        row.req.rgbw_in  = colour;
        row.known        = known;
        row.res          = res;
        drive_table.push_back(row);
    endtask

    // Drop the request valid and let the pipeline drain
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Write the whole register file, one transaction per register
    task automatic load_cfg(input t_mapper_cfg c, input bit scramble);
        t_cfg_reg reg_sel;
        int       k;
        for (k = 0; k < 8; k++) begin
            reg_sel = t_cfg_reg'(k);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= reg_sel;
            i_cfg_data  <= reg_word(c, reg_sel, scramble ? $urandom : 32'd0);
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        live_cfg = c;
    endtask

    // One request transaction after a random gap; queues its expected result
    task automatic draw_pixel(input t_pix_req rq, input bit known, input t_pix_res res);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= rq;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        pending_results.push_back(known ? res : map_pixel(rq, live_cfg));
    endtask

    // Result side: check each transaction, then stall for a random hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_hold = 0;
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result transaction with no request pending");
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_res.accepted !== want.accepted) begin
                        $error("accepted: expected %0d, actual %0d",
                               want.accepted, o_out_res.accepted);
                        errors++;
                    end
                    if (o_out_res.led_index !== want.led_index) begin
                        $error("led_index: expected %0d, actual %0d",
                               want.led_index, o_out_res.led_index);
                        errors++;
                    end
                    if (o_out_res.byte_address !== want.byte_address) begin
                        $error("byte_address: expected %0d, actual %0d",
                               want.byte_address, o_out_res.byte_address);
                        errors++;
                    end
                    if (o_out_res.four_byte_mode !== want.four_byte_mode) begin
                        $error("four_byte_mode: expected %0d, actual %0d",
                               want.four_byte_mode, o_out_res.four_byte_mode);
                        errors++;
                    end
                    if (o_out_res.slot_byte0 !== want.slot_byte0) begin
                        $error("slot_byte0: expected %0h, actual %0h",
                               want.slot_byte0, o_out_res.slot_byte0);
                        errors++;
                    end
                    if (o_out_res.slot_byte1 !== want.slot_byte1) begin
                        $error("slot_byte1: expected %0h, actual %0h",
                               want.slot_byte1, o_out_res.slot_byte1);
                        errors++;
                    end
                    if (o_out_res.slot_byte2 !== want.slot_byte2) begin
                        $error("slot_byte2: expected %0h, actual %0h",
                               want.slot_byte2, o_out_res.slot_byte2);
                        errors++;
                    end
                    if (o_out_res.slot_byte3 !== want.slot_byte3) begin
                        $error("slot_byte3: expected %0h, actual %0h",
                               want.slot_byte3, o_out_res.slot_byte3);
                        errors++;
                    end
                end
                out_hold = no_idle ? 0 : $urandom_range(0, 3);
            end else if (out_hold != 0) begin
                out_hold--;
            end
            i_out_stall <= (out_hold != 0);
        end
    end

    // Hard stop in case the pipeline hangs
    initial begin
        #(RUN_LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        t_mapper_cfg base, c;
        t_table_row  row;
        int          ph, n, m;
        t_cfg_style  style;

        base = live_cfg;

        // values right after reset: GRB order, 16x16 matrix
        add_row(base, 0, 0, 32'h1122_3344, 1'b1,
                t_pix_res'{1'b1, 16'd0, 18'd0, 1'b0, 8'h33, 8'h22, 8'h44, 8'h00});
        add_row(base, 15, 15, 32'hFFFF_FFFF, 1'b1,
                t_pix_res'{1'b1, 16'd255, 18'd765, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h00});
        // off-matrix and negative coordinates
        add_row(base, -1, 0, 32'hFFFF_FFFF, 1'b1, '0);
        add_row(base, 0, -32768, 32'hFFFF_FFFF, 1'b1, '0);
        add_row(base, 16, 0, 32'hFFFF_FFFF, 1'b1, '0);
        add_row(base, 0, 16, 32'hFFFF_FFFF, 1'b1, '0);
        add_row(base, 32767, 32767, 32'hFFFF_FFFF, 1'b1, '0);
        add_row(base, -32768, -1, 32'hFFFF_FFFF, 1'b1, '0);

        // start corners, column layout and zigzag on a 5x3 matrix
        c = base;
        c.width_cols   = 9'd5;
        c.height_rows  = 9'd3;
        c.strip_length = 16'd15;
        for (m = 1; m <= 8; m = m << 1) begin
            c.layout_mode = 4'(m);
            add_row(c, 3, 1, 32'h0102_0304, 1'b0, '0);
        end
        c.layout_mode = 4'hF;
        add_row(c, 3, 1, 32'h0102_0304, 1'b0, '0);

        // index against strip length: last one in, first one out
        c = base;
        c.strip_length = 16'd100;
        add_row(c, 3, 6, 32'hA5A5_5A5A, 1'b0, '0);
        add_row(c, 4, 6, 32'hA5A5_5A5A, 1'b1, '0);

        // zero width rejects everything
        c = base;
        c.width_cols = 9'd0;
        add_row(c, 0, 0, 32'h1234_5678, 1'b1, '0);

        // oversize dimensions, bounded by the strip length
        c = base;
        c.width_cols   = 9'd511;
        c.height_rows  = 9'd511;
        c.strip_length = 16'hFFFF;
        add_row(c, 0, 128, 32'h1234_5678, 1'b0, '0);
        add_row(c, 510, 128, 32'h1234_5678, 1'b1, '0);

        // RGBW with white first
        c = base;
        c.channel_order = 8'h1B;
        add_row(c, 1, 0, 32'h1122_3344, 1'b1,
                t_pix_res'{1'b1, 16'd1, 18'd4, 1'b1, 8'h11, 8'h22, 8'h33, 8'h44});
        // all channels on one offset
        c.channel_order = 8'h00;
        add_row(c, 2, 3, 32'h1122_3344, 1'b0, '0);
        // three-byte mode with channels on the dropped offset
        c.channel_order = 8'h5F;
        add_row(c, 2, 3, 32'h1122_3344, 1'b0, '0);
        // override colour with dimming
        c.channel_order   = 8'h1B;
        c.override_enable = 1'b1;
        c.override_colour = 32'hFF80_4020;
        c.dim_level       = 8'd128;
        add_row(c, 4, 5, 32'h1122_3344, 1'b0, '0);
        // full brightness scale on full channels
        c.override_enable = 1'b0;
        c.dim_level       = 8'd255;
        add_row(c, 4, 5, 32'hFFFF_FFFF, 1'b0, '0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table; registers change only with the pipeline empty
        foreach (drive_table[i]) begin
            row = drive_table[i];
            if (row.cfg != live_cfg) begin
                wait_idle();
                load_cfg(row.cfg, 1'b0);
            end
            draw_pixel(row.req, row.known, row.res);
        end

        // random phases, each under a fresh register setting
        for (ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            if (ph == 0)
                style = STYLE_DEFAULT;
            else if (ph == 1)
                style = STYLE_MAX;
            else if (ph == 2)
                style = STYLE_MIN;
            else if (ph % 4 == 0)
                style = STYLE_FULL;
            else
                style = STYLE_SMALL;
            no_idle = (ph % 5 == 3);
            load_cfg(rand_cfg(style), 1'b1);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // sender holds off until the pipeline has drained
                if (n == PHASE_ITEMS / 2 && ph % 3 == 1)
                    wait_idle();
                draw_pixel(rand_pixel(live_cfg), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
